FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted (active low).
`define MTK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mtk assertion failed");

// Clocked check that also holds during reset.
`define MTK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mtk assertion failed");

`endif

FILE: hw/rtl/mtk_pkg.sv
package mtk_pkg;

    localparam int LINE_LENGTH_DEF = 32;

    localparam logic [8:0] PAIR_CLEAR = 9'h006;
    localparam logic [8:0] PAIR_MODE  = 9'h030;
    localparam logic [8:0] PAIR_SPACE = 9'h180;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] DIGIT_BASE = 8'h31;

    localparam logic [3:0] BCD_NINE = 4'd9;
    localparam logic [1:0] TAP_LAST = 2'd2;

    typedef logic [3:0] t_bcd;

    typedef struct packed {
        t_bcd thousands;
        t_bcd hundreds;
        t_bcd tens;
        t_bcd ones;
    } t_count;

    // multi-tap letter table, three letters per key
    function automatic logic [7:0] letter_code(input logic [3:0] key, input logic [1:0] tap);
        logic [23:0] row;
        row = 24'h000000;
        unique case (key)
            4'd0:    row = {"Z", "Q", "."};
            4'd1:    row = {"C", "B", "A"};
            4'd2:    row = {"F", "E", "D"};
            4'd3:    row = {"I", "H", "G"};
            4'd4:    row = {"L", "K", "J"};
            4'd5:    row = {"O", "N", "M"};
            4'd6:    row = {"S", "R", "P"};
            4'd7:    row = {"V", "U", "T"};
            4'd8:    row = {"Y", "X", "W"};
            default: row = 24'h000000;
        endcase
        unique case (tap)
            2'd0:    return row[7:0];
            2'd1:    return row[15:8];
            2'd2:    return row[23:16];
            default: return row[7:0];
        endcase
    endfunction

    // index of the highest key down
    function automatic logic [3:0] top_key(input logic [8:0] keys);
        logic [3:0] idx;
        idx = 4'd0;
        for (int k = 0; k < 9; k++) begin
            if (keys[k]) begin
                idx = 4'(k);
            end
        end
        return idx;
    endfunction

    // decimal increment, wraps at 9999
    function automatic t_count count_inc(input t_count c);
        t_count n;
        n = c;
        if (c.ones != BCD_NINE) begin
            n.ones = c.ones + 4'd1;
        end else begin
            n.ones = 4'd0;
            if (c.tens != BCD_NINE) begin
                n.tens = c.tens + 4'd1;
            end else begin
                n.tens = 4'd0;
                if (c.hundreds != BCD_NINE) begin
                    n.hundreds = c.hundreds + 4'd1;
                end else begin
                    n.hundreds = 4'd0;
                    if (c.thousands != BCD_NINE) begin
                        n.thousands = c.thousands + 4'd1;
                    end else begin
                        n.thousands = 4'd0;
                    end
                end
            end
        end
        return n;
    endfunction

endpackage

FILE: hw/rtl/mtk_line_mem.sv
module mtk_line_mem #(
    parameter int LINE_LENGTH = mtk_pkg::LINE_LENGTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(LINE_LENGTH)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic [$clog2(LINE_LENGTH)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [LINE_LENGTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/multitap_keypad_text_entry.sv
// channel  dir  signals                      word
// s_axis   in   tvalid tready tdata[15:0]    one keypad snapshot
// m_axis   out  tvalid tready tdata[31:0]    one line position, LINE_LENGTH per snapshot
//                 tlast tuser[0]
//
// One snapshot runs an update (accept, decode and write, 0-2 counter steps, read
// prime) and then streams LINE_LENGTH output words.
// The line lives in a circular buffer; one modular address adder serves the write
// and every read. Scrolling moves the head pointer, clearing resets the fill count.
// Reset is synchronous, active low. s_axis is not ready until the last position
// of the line has been taken; m_axis stalls hold the current word.
`include "assert_macros.svh"

module multitap_keypad_text_entry #(
    parameter int LINE_LENGTH = mtk_pkg::LINE_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [8:0] keys_pressed, [15:9] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] position, [12:5] character, [16:13] count_thousands,
    // [20:17] count_hundreds, [24:21] count_tens, [28:25] count_ones, [31:29] zero
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,  // last_of_run
    output logic [0:0]  o_m_axis_tuser   // [0] letter_mode
);

    localparam int PW = $clog2(LINE_LENGTH);
    localparam int FW = $clog2(LINE_LENGTH + 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(LINE_LENGTH);
    localparam logic [PW-1:0] LAST_POS  = PW'(LINE_LENGTH - 1);
    localparam logic [PW:0]   LEN_WIDE  = (PW + 1)'(LINE_LENGTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COUNT,
        ST_STREAM
    } t_state;

    t_state          r_state;
    logic [8:0]      r_keys;
    logic [PW-1:0]   r_head;
    logic [FW-1:0]   r_fill;
    logic            r_mode;
    logic [3:0]      r_last_key;
    logic [1:0]      r_tap;
    mtk_pkg::t_count r_count;
    logic [1:0]      r_inc;
    logic [PW-1:0]   r_pos;

    logic [3:0]    key;
    logic          any_key;
    logic          is_clear;
    logic          is_mode;
    logic          is_space;
    logic          is_single;
    logic [1:0]    tap_step;
    logic [1:0]    tap_eff;
    logic          replace;
    logic          do_append;
    logic [7:0]    append_char;
    logic [7:0]    wr_data;
    logic [PW-1:0] wr_off;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] add_b;
    logic [PW:0]   add_sum;
    logic [PW-1:0] phys_addr;
    logic [PW-1:0] head_next;
    logic          wr_en;
    logic [7:0]    w_rd_data;

    always_comb begin
        key       = mtk_pkg::top_key(r_keys);
        any_key   = |r_keys;
        is_clear  = (r_keys & mtk_pkg::PAIR_CLEAR) == mtk_pkg::PAIR_CLEAR;
        is_mode   = !is_clear && ((r_keys & mtk_pkg::PAIR_MODE) == mtk_pkg::PAIR_MODE);
        is_space  = !is_clear && !is_mode
                    && ((r_keys & mtk_pkg::PAIR_SPACE) == mtk_pkg::PAIR_SPACE);
        is_single = !is_clear && !is_mode && !is_space && any_key;

        if (r_last_key != key || r_tap == mtk_pkg::TAP_LAST) begin
            tap_step = 2'd0;
        end else begin
            tap_step = r_tap + 2'd1;
        end
        // repeat tap on an empty line starts a new character
        tap_eff = (r_mode && r_fill == '0) ? 2'd0 : tap_step;
        replace = is_single && r_mode && tap_eff != 2'd0;

        if (is_space) begin
            append_char = mtk_pkg::CHAR_SPACE;
        end else if (r_mode) begin
            append_char = mtk_pkg::letter_code(key, 2'd0);
        end else begin
            append_char = mtk_pkg::DIGIT_BASE + {4'd0, key};
        end
        do_append = is_space || (is_single && !replace);
        wr_data   = replace ? mtk_pkg::letter_code(key, tap_eff) : append_char;

        if (replace) begin
            wr_off = PW'(r_fill - FW'(1));
        end else if (r_fill == FILL_FULL) begin
            wr_off = '0;
        end else begin
            wr_off = PW'(r_fill);
        end

        if (r_state == ST_STREAM && i_m_axis_tready && r_pos != LAST_POS) begin
            n_pos = r_pos + PW'(1);
        end else if (r_state == ST_STREAM) begin
            n_pos = r_pos;
        end else begin
            n_pos = '0;
        end

        // shared modular address adder
        add_b   = (r_state == ST_DECODE) ? wr_off : n_pos;
        add_sum = {1'b0, r_head} + {1'b0, add_b};
        if (add_sum >= LEN_WIDE) begin
            phys_addr = PW'(add_sum - LEN_WIDE);
        end else begin
            phys_addr = PW'(add_sum);
        end

        head_next = (r_head == LAST_POS) ? '0 : r_head + PW'(1);
        wr_en     = (r_state == ST_DECODE) && (do_append || replace);
    end

    mtk_line_mem #(
        .LINE_LENGTH(LINE_LENGTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (phys_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (phys_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_keys     <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_mode     <= 1'b1;
            r_last_key <= '0;
            r_tap      <= '0;
            r_count    <= '0;
            r_inc      <= '0;
            r_pos      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_keys  <= i_s_axis_tdata[8:0];
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (is_clear) begin
                        r_fill <= '0;
                    end
                    if (is_mode) begin
                        r_mode <= !r_mode;
                    end
                    if (is_single) begin
                        r_last_key <= key;
                        r_tap      <= tap_eff;
                    end
                    if (do_append) begin
                        if (r_fill == FILL_FULL) begin
                            r_head <= head_next;
                        end else begin
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                    if (is_single) begin
                        r_inc <= 2'd1;
                    end else if (any_key && !is_single) begin
                        r_inc <= 2'd2;
                    end else begin
                        r_inc <= 2'd0;
                    end
                    r_state <= ST_COUNT;
                end
                ST_COUNT: begin
                    if (r_inc != 2'd0) begin
                        r_count <= mtk_pkg::count_inc(r_count);
                        r_inc   <= r_inc - 2'd1;
                    end else begin
                        r_pos   <= n_pos;
                        r_state <= ST_STREAM;
                    end
                end
                ST_STREAM: begin
                    r_pos <= n_pos;
                    if (i_m_axis_tready && r_pos == LAST_POS) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_STREAM);
    assign o_m_axis_tdata  = {3'd0,
                              r_count.ones, r_count.tens, r_count.hundreds, r_count.thousands,
                              (FW'(r_pos) < r_fill) ? w_rd_data : 8'd0,
                              5'(r_pos)};
    assign o_m_axis_tlast  = (r_pos == LAST_POS);
    assign o_m_axis_tuser  = r_mode;

    `MTK_ASSERT(a_busy_while_streaming, i_clk, i_rst_n, o_m_axis_tvalid |-> !o_s_axis_tready)
    `MTK_ASSERT(a_accept_to_decode, i_clk, i_rst_n,
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == ST_DECODE))
    `MTK_ASSERT(a_stall_holds_char, i_clk, i_rst_n,
        (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(w_rd_data))
    `MTK_ASSERT_ALWAYS(a_fill_head_range, i_clk,
        !i_rst_n || ((r_fill <= FILL_FULL) && ({1'b0, r_head} < LEN_WIDE)))

endmodule
